[hdl/cbmp_pkg.sv]
// ----------------------------------------------------------------------------
// cbmp_pkg: shared types and constants
// opcodes, result kinds, register indexes and sequencer states for the
// bmp pixel streamer with colormap
// ----------------------------------------------------------------------------
package cbmp_pkg;

  localparam int unsigned MaxDimension = 4096;
  localparam int unsigned MaxKeys      = 5;
  localparam int unsigned FractionBits = 16;

  localparam int unsigned ColsW  = 13;
  localparam int unsigned RowsW  = 14;
  localparam int unsigned RowW   = 13;
  localparam int unsigned ColW   = 12;
  localparam int unsigned KeyW   = 56;
  localparam int unsigned KeyIdxW = 3;
  localparam int unsigned MagW   = 32;
  localparam int unsigned NumW   = MagW + 1;
  localparam int unsigned TotW   = NumW + 8;

  localparam logic [1:0] OpStart  = 2'd0;
  localparam logic [1:0] OpDirect = 2'd1;
  localparam logic [1:0] OpMap    = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

  localparam logic [1:0] KindPixel  = 2'd0;
  localparam logic [1:0] KindPad    = 2'd1;
  localparam logic [1:0] KindStart  = 2'd2;
  localparam logic [1:0] KindReject = 2'd3;

  localparam logic [2:0] RegCols = 3'd0;
  localparam logic [2:0] RegRows = 3'd1;
  localparam logic [2:0] RegKeys = 3'd2;
  localparam logic [2:0] RegKey0 = 3'd3;
  localparam logic [2:0] RegKey1 = 3'd4;
  localparam logic [2:0] RegKey2 = 3'd5;
  localparam logic [2:0] RegKey3 = 3'd6;
  localparam logic [2:0] RegKey4 = 3'd7;

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StSearch = 7'b0000010,
    StPrep   = 7'b0000100,
    StMul0   = 7'b0001000,
    StMul1   = 7'b0010000,
    StDiv    = 7'b0100000,
    StEmit   = 7'b1000000
  } state_e;

  typedef logic [KeyW-1:0] key_t;

  // colour byte of a key: channel 0 red, 1 green, 2 blue
  function automatic logic [7:0] key_chan(input key_t key, input logic [1:0] ch);
    logic [7:0] res;
    case (ch)
      2'd0:    res = key[23:16];
      2'd1:    res = key[15:8];
      default: res = key[7:0];
    endcase
    return res;
  endfunction

  function automatic logic signed [MagW-1:0] key_thresh(input key_t key);
    return signed'(key[55:24]);
  endfunction

endpackage

[hdl/colormap_bmp_pixel_stream_top.sv]
// ----------------------------------------------------------------------------
// colormap_bmp_pixel_stream_top: 24-bit bmp pixel byte streamer
// turns start and pixel requests into bgr bytes with row padding, mapping
// magnitudes through a piecewise linear colormap
// ----------------------------------------------------------------------------
// usage
//   slave stream: one request per item; tuser holds the opcode (start frame,
//   direct rgb pixel, magnitude pixel), tdata holds red, green, blue and a
//   signed q16.16 magnitude
//   master stream: one byte result per beat; tlast marks the final result of
//   a request, tuser carries the kind and the frame done flag, tdata carries
//   the byte and the row and column of the next pixel
//   apb port: 64-bit registers at byte address 8*i, written while idle
// timing
//   the block takes one request at a time and drops tready until the last
//   result of that request is loaded into the output register
//   start, reject and direct pixel requests: setup, then one result byte per
//   cycle while the output register can load (1, or 3 to 6 bytes)
//   magnitude pixel: setup, a key search over the n keys in use, then, if a
//   segment matches, a prep step and, for each channel, the a*den and (b-a)*num
//   passes of the one shared multiplier and the 8-step restoring divider; then bytes
//   a stalled receiver simply holds the output register and the sequencer
// reset
//   frame closed, position zero, 1 column, 1 row, one key, keys zero
// ----------------------------------------------------------------------------
module colormap_bmp_pixel_stream_top import cbmp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // red, green, blue, magnitude
  input  logic [1:0]  s_axis_tuser,   // opcode
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out_byte, next_row, next_column, zero fill
  output logic [2:0]  m_axis_tuser,   // kind, frame_done
  output logic        m_axis_tlast,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [ColsW-1:0]        cols_q;
  logic signed [RowsW-1:0] rows_q;
  logic [2:0]              keys_q;
  key_t                    key_q [MaxKeys];

  // frame state
  logic                    open_q;
  logic signed [RowW-1:0]  row_q;
  logic [ColW-1:0]         col_q;
  logic [ColsW-1:0]        fcols_q;
  logic signed [RowsW-1:0] frows_q;

  // sequencer
  state_e                  state_q;
  logic signed [MagW-1:0]  mag_q;
  logic [KeyIdxW-1:0]      sidx_q;
  logic                    le0_q, pgt_q, found_q;
  key_t                    pkey_q, lo_q, hi_q;
  logic [NumW-1:0]         num_q, den_q;
  logic [TotW-1:0]         tot_q;
  logic [7:0]              quo_q;
  logic [2:0]              bit_q;
  logic [1:0]              ch_q;
  logic [7:0]              rgb_q [3];

  // emission
  logic                    em_single_q;
  logic [1:0]              em_kind_q;
  logic [2:0]              em_total_q, em_idx_q;
  logic                    em_done_q;

  // output register
  logic                    m_valid_q;
  logic [7:0]              m_byte_q;
  logic [1:0]              m_kind_q;
  logic                    m_last_q, m_done_q;
  logic signed [RowW-1:0]  m_row_q;
  logic [ColW-1:0]         m_col_q;

  assign pready = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'd0, m_col_q, m_row_q, m_byte_q};
  assign m_axis_tuser  = {m_done_q, m_kind_q};
  assign m_axis_tlast  = m_last_q;

  logic [2:0] cfg_idx;
  assign cfg_idx = paddr[5:3];

  always_comb begin
    case (cfg_idx)
      RegCols: prdata = {51'd0, cols_q};
      RegRows: prdata = {50'd0, rows_q};
      RegKeys: prdata = {61'd0, keys_q};
      RegKey0: prdata = {8'd0, key_q[0]};
      RegKey1: prdata = {8'd0, key_q[1]};
      RegKey2: prdata = {8'd0, key_q[2]};
      RegKey3: prdata = {8'd0, key_q[3]};
      default: prdata = {8'd0, key_q[4]};
    endcase
  end

  // keys in use, clamped to one..MaxKeys
  logic [2:0] nkeys;
  always_comb begin
    if (keys_q == 3'd0) nkeys = 3'd1;
    else if (keys_q > 3'(MaxKeys)) nkeys = 3'(MaxKeys);
    else nkeys = keys_q;
  end

  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;

  logic [1:0] in_op;
  assign in_op = s_axis_tuser;

  // start validity
  logic size_ok;
  assign size_ok = (rows_q != '0) &&
                   (rows_q >= -$signed(15'(MaxDimension))) &&
                   (rows_q <= $signed(15'(MaxDimension))) &&
                   (cols_q != '0) && (cols_q <= ColsW'(MaxDimension));

  // position update of a pixel
  logic [ColsW-1:0]        col_inc;
  logic                    row_end;
  logic signed [RowsW-1:0] row_step;
  logic                    frame_end;
  assign col_inc  = {1'b0, col_q} + 1'b1;
  assign row_end  = col_inc >= fcols_q;
  assign row_step = (frows_q < 0) ? {row_q[RowW-1], row_q} + 14'sd1
                                  : {row_q[RowW-1], row_q} - 14'sd1;
  assign frame_end = row_end && ((frows_q < 0)
                     ? ($signed({row_step[RowsW-1], row_step}) >=
                        -$signed({frows_q[RowsW-1], frows_q}))
                     : (row_step < 0));

  // search step
  key_t cur_key;
  logic cur_gt, cur_match;
  assign cur_key   = key_q[sidx_q];
  assign cur_gt    = mag_q > key_thresh(cur_key);
  assign cur_match = (sidx_q != '0) && pgt_q && !cur_gt;

  // shared multiplier and divider step
  logic [7:0]              ch_a, ch_b;
  logic signed [8:0]       ch_diff;
  logic signed [8:0]       mul_a;
  logic signed [33:0]      mul_b;
  logic signed [42:0]      mul_prod;
  logic signed [42:0]      mul_sum;
  logic [TotW-1:0]         div_sh;
  logic                    div_ge;
  logic [7:0]              quo_n;
  assign ch_a     = key_chan(lo_q, ch_q);
  assign ch_b     = key_chan(hi_q, ch_q);
  assign ch_diff  = $signed({1'b0, ch_b}) - $signed({1'b0, ch_a});
  // first pass a*den, second pass (b-a)*num
  assign mul_a    = (state_q == StMul0) ? $signed({1'b0, ch_a}) : ch_diff;
  assign mul_b    = (state_q == StMul0) ? $signed({1'b0, den_q})
                                        : $signed({1'b0, num_q});
  assign mul_prod = mul_a * mul_b;
  assign mul_sum  = $signed({2'b00, tot_q}) + mul_prod;
  assign div_sh   = {8'd0, den_q} << bit_q;
  assign div_ge   = tot_q >= div_sh;
  always_comb begin
    quo_n = quo_q;
    quo_n[bit_q] = div_ge;
  end

  logic load;
  assign load = !m_valid_q || m_axis_tready;

  logic [7:0] em_byte;
  logic [1:0] em_kind;
  logic       em_last;
  always_comb begin
    em_last = (em_idx_q == em_total_q - 3'd1);
    if (em_single_q) begin
      em_byte = 8'd0;
      em_kind = em_kind_q;
    end else begin
      case (em_idx_q)
        3'd0:    em_byte = rgb_q[2];
        3'd1:    em_byte = rgb_q[1];
        3'd2:    em_byte = rgb_q[0];
        default: em_byte = 8'd0;
      endcase
      em_kind = (em_idx_q < 3'd3) ? KindPixel : KindPad;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= ColsW'(1);
      rows_q <= RowsW'(1);
      keys_q <= 3'd1;
      for (int i = 0; i < MaxKeys; i++) key_q[i] <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (cfg_idx)
        RegCols: cols_q <= pwdata[ColsW-1:0];
        RegRows: rows_q <= pwdata[RowsW-1:0];
        RegKeys: keys_q <= pwdata[2:0];
        RegKey0: key_q[0] <= pwdata[KeyW-1:0];
        RegKey1: key_q[1] <= pwdata[KeyW-1:0];
        RegKey2: key_q[2] <= pwdata[KeyW-1:0];
        RegKey3: key_q[3] <= pwdata[KeyW-1:0];
        default: key_q[4] <= pwdata[KeyW-1:0];
      endcase
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      open_q    <= 1'b0;
      row_q     <= '0;
      col_q     <= '0;
      fcols_q   <= ColsW'(1);
      frows_q   <= RowsW'(1);
      m_valid_q <= 1'b0;
    end else begin
      if (state_q == StEmit && load) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;

      case (state_q)
        StIdle: begin
          if (accept) begin
            state_q <= StEmit;
            if (in_op == OpStart) begin
              if (size_ok) begin
                open_q  <= 1'b1;
                fcols_q <= cols_q;
                frows_q <= rows_q;
                row_q   <= (rows_q < 0) ? '0 : RowW'(rows_q - 14'sd1);
                col_q   <= '0;
              end
            end else if (in_op != OpDirect && in_op != OpMap || !open_q) begin
              // reject, frame state unchanged
            end else begin
              if (in_op == OpMap) state_q <= StSearch;
              if (row_end) begin
                col_q <= '0;
                if (frame_end) begin
                  open_q <= 1'b0;
                  row_q  <= -13'sd1;
                end else begin
                  row_q <= RowW'(row_step);
                end
              end else begin
                col_q <= col_inc[ColW-1:0];
              end
            end
          end
        end
        StSearch: begin
          if (sidx_q == nkeys - 3'd1)
            state_q <= (found_q || cur_match) ? StPrep : StEmit;
        end
        StPrep:  state_q <= StMul0;
        StMul0:  state_q <= StMul1;
        StMul1:  state_q <= StDiv;
        StDiv: begin
          if (bit_q == 3'd0) state_q <= (ch_q == 2'd2) ? StEmit : StMul0;
        end
        StEmit: begin
          if (load && em_last) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        mag_q      <= s_axis_tdata[55:24];
        rgb_q[0]   <= s_axis_tdata[7:0];
        rgb_q[1]   <= s_axis_tdata[15:8];
        rgb_q[2]   <= s_axis_tdata[23:16];
        sidx_q     <= '0;
        found_q    <= 1'b0;
        em_idx_q   <= '0;
        em_done_q  <= frame_end;
        if (in_op == OpStart) begin
          em_single_q <= 1'b1;
          em_kind_q   <= size_ok ? KindStart : KindReject;
          em_total_q  <= 3'd1;
        end else if (in_op != OpDirect && in_op != OpMap || !open_q) begin
          em_single_q <= 1'b1;
          em_kind_q   <= KindReject;
          em_total_q  <= 3'd1;
        end else begin
          em_single_q <= 1'b0;
          em_kind_q   <= KindPixel;
          em_total_q  <= 3'd3 + (row_end ? {1'b0, fcols_q[1:0]} : 3'd0);
        end
      end
      StSearch: begin
        sidx_q <= sidx_q + 3'd1;
        pgt_q  <= cur_gt;
        pkey_q <= cur_key;
        if (sidx_q == '0) begin
          le0_q <= !cur_gt;
          for (int c = 0; c < 3; c++) rgb_q[c] <= key_chan(cur_key, 2'(c));
        end else if (!le0_q) begin
          for (int c = 0; c < 3; c++) rgb_q[c] <= key_chan(cur_key, 2'(c));
        end
        if (cur_match) begin
          found_q <= 1'b1;
          lo_q    <= pkey_q;
          hi_q    <= cur_key;
        end
      end
      StPrep: begin
        num_q <= NumW'($signed({mag_q[MagW-1], mag_q}) -
                       $signed({lo_q[55], key_thresh(lo_q)}));
        den_q <= NumW'($signed({hi_q[55], key_thresh(hi_q)}) -
                       $signed({lo_q[55], key_thresh(lo_q)}));
        ch_q  <= 2'd0;
      end
      StMul0: begin
        tot_q <= mul_prod[TotW-1:0];
        quo_q <= '0;
        bit_q <= 3'd7;
      end
      StMul1: tot_q <= mul_sum[TotW-1:0];
      StDiv: begin
        if (div_ge) tot_q <= tot_q - div_sh;
        quo_q <= quo_n;
        bit_q <= bit_q - 3'd1;
        if (bit_q == 3'd0) begin
          rgb_q[ch_q] <= quo_n;
          ch_q <= ch_q + 2'd1;
        end
      end
      StEmit: begin
        if (load) begin
          em_idx_q <= em_idx_q + 3'd1;
          m_byte_q <= em_byte;
          m_kind_q <= em_kind;
          m_last_q <= em_last;
          m_done_q <= em_last && em_done_q && !em_single_q;
          m_row_q  <= row_q;
          m_col_q  <= col_q;
        end
      end
      default: ;
    endcase
  end

endmodule

[verif/colormap_bmp_pixel_stream_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// colormap_bmp_pixel_stream_top_tb: self-checking bench for the bmp streamer
// drives start, direct, magnitude pixel and unused opcode requests with random gaps and
// output stalls, predicts every byte, kind, flag and position, and compares
// ----------------------------------------------------------------------------
module colormap_bmp_pixel_stream_top_tb import cbmp_pkg::*;;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  kind;
    logic        last;
    logic        done;
    logic [12:0] row;
    logic [11:0] col;
  } bmp_beat_t;

  // byte stream predictor with its own register and frame state
  class bmp_scoreboard;
    logic [12:0] cols_q;
    logic signed [13:0] rows_q;
    logic [2:0]  keys_q;
    logic [55:0] key_q [5];
    bit          open_q;
    int          row_q, col_q, fcols, frows;
    bmp_beat_t   beats_q[$];
    int          errors, shown;

    function void reset_state();
      cols_q = 1; rows_q = 1; keys_q = 1;
      foreach (key_q[i]) key_q[i] = '0;
      open_q = 0; row_q = 0; col_q = 0; fcols = 1; frows = 1;
      errors = 0; shown = 0;
    endfunction

    function void write_reg(int idx, logic [63:0] val);
      case (idx)
        RegCols: cols_q = val[12:0];
        RegRows: rows_q = val[13:0];
        RegKeys: keys_q = val[2:0];
        default: if (idx <= 7) key_q[idx-3] = val[55:0];
      endcase
    endfunction

    function longint thresh(int i);
      logic signed [31:0] t;
      t = key_q[i][55:24];
      return longint'(t);
    endfunction

    function logic [7:0] chan(int i, int c);
      return key_q[i][23-8*c -: 8];
    endfunction

    function void push(logic [7:0] b, logic [1:0] k, logic l, logic d);
      bmp_beat_t e;
      e.out_byte = b; e.kind = k; e.last = l; e.done = d;
      e.row = row_q[12:0]; e.col = col_q[11:0];
      beats_q.push_back(e);
    endfunction

    // note one accepted request and queue the bytes it causes
    function void note_request(logic [1:0] op, logic [55:0] data);
      logic [7:0] rgb [3];
      logic signed [31:0] mag;
      longint x, lo, hi, a, b2, num, den;
      int n, absr, pad;
      bit done;
      done = 0;
      if (op == OpStart) begin
        absr = rows_q < 0 ? -int'(rows_q) : int'(rows_q);
        if (rows_q == 0 || absr > MaxDimension || cols_q < 1 || cols_q > MaxDimension) begin
          push(8'd0, KindReject, 1, 0);
          return;
        end
        open_q = 1; fcols = cols_q; frows = rows_q;
        row_q = rows_q < 0 ? 0 : int'(rows_q) - 1;
        col_q = 0;
        push(8'd0, KindStart, 1, 0);
        return;
      end
      if (op == OpUnused || !open_q) begin
        push(8'd0, KindReject, 1, 0);
        return;
      end
      if (op == OpDirect) begin
        rgb[0] = data[7:0]; rgb[1] = data[15:8]; rgb[2] = data[23:16];
      end else begin
        mag = data[55:24];
        x = longint'(mag);
        n = keys_q;
        if (n < 1) n = 1;
        if (n > MaxKeys) n = MaxKeys;
        for (int c = 0; c < 3; c++) rgb[c] = chan(n-1, c);
        if (x <= thresh(0)) for (int c = 0; c < 3; c++) rgb[c] = chan(0, c);
        for (int i = 0; i + 1 < n; i++) begin
          lo = thresh(i); hi = thresh(i+1);
          if (x > lo && x <= hi) begin
            num = x - lo; den = hi - lo;
            for (int c = 0; c < 3; c++) begin
              a = chan(i, c); b2 = chan(i+1, c);
              rgb[c] = 8'((a * den + (b2 - a) * num) / den);
            end
          end
        end
      end
      col_q++;
      pad = 0;
      if (col_q >= fcols) begin
        pad = fcols % 4;
        col_q = 0;
        if (frows < 0) begin
          row_q++;
          if (row_q >= -frows) done = 1;
        end else begin
          row_q--;
          if (row_q <= -1) done = 1;
        end
        if (done) begin
          open_q = 0; row_q = -1;
        end
      end
      push(rgb[2], KindPixel, 0, 0);
      push(rgb[1], KindPixel, 0, 0);
      push(rgb[0], KindPixel, pad == 0, done && pad == 0);
      for (int p = 0; p < pad; p++) push(8'd0, KindPad, p + 1 == pad, done && p + 1 == pad);
    endfunction

    function void flag(string what);
      errors++;
      if (shown < 10) begin
        shown++;
        $display("mismatch: %s", what);
      end
    endfunction

    // compare one output beat against the oldest queued byte
    function void check_beat(bmp_beat_t got);
      bmp_beat_t e;
      if (beats_q.size() == 0) begin
        flag($sformatf("unexpected beat byte=%h kind=%0d", got.out_byte, got.kind));
        return;
      end
      e = beats_q.pop_front();
      if (got != e)
        flag($sformatf({"exp byte=%h kind=%0d last=%b done=%b row=%h col=%h, ",
                        "got byte=%h kind=%0d last=%b done=%b row=%h col=%h"},
          e.out_byte, e.kind, e.last, e.done, e.row, e.col,
          got.out_byte, got.kind, got.last, got.done, got.row, got.col));
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [39:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  colormap_bmp_pixel_stream_top uut (.*);

  bmp_scoreboard sb = new();
  bit   burst_mode = 0;   // no idling on either side while set
  int   cycle_cnt = 0;
  int   stall_left = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 300000) begin
      $display("[colormap_bmp_pixel_stream_top] ERROR");
      $finish;
    end
    if (cycle_cnt % 300 == 0) burst_mode <= ($urandom_range(0, 3) == 0);
  end

  // receiver: random stall per beat, check at the accepting edge
  always @(posedge clk_i) begin
    bmp_beat_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.out_byte = m_axis_tdata[7:0];
      got.row      = m_axis_tdata[20:8];
      got.col      = m_axis_tdata[32:21];
      got.kind     = m_axis_tuser[1:0];
      got.done     = m_axis_tuser[2];
      got.last     = m_axis_tlast;
      sb.check_beat(got);
      stall_left = burst_mode ? 0 : $urandom_range(0, 5);
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready = 0;
      stall_left--;
    end else begin
      m_axis_tready = 1;
    end
  end

  task automatic apb_write(int idx, logic [63:0] val);
    @(negedge clk_i);
    psel = 1; penable = 0; pwrite = 1; paddr = 6'(idx * 8); pwdata = val;
    @(negedge clk_i);
    penable = 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  // one request: random gap, then hold until taken
  task automatic send_request(logic [1:0] op, logic [7:0] r, logic [7:0] g,
                              logic [7:0] b, logic [31:0] mag);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 5);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1;
    s_axis_tuser  = op;
    s_axis_tdata  = {mag, b, g, r};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(op, s_axis_tdata);
  endtask

  task automatic send_pixel_rand(int mag_lo, int mag_hi);
    logic [1:0] op;
    logic [31:0] mag;
    op = $urandom_range(0, 1) ? OpMap : OpDirect;
    if ($urandom_range(0, 4) == 0) mag = $urandom();
    else mag = 32'($urandom_range(0, mag_hi - mag_lo) + mag_lo);
    send_request(op, $urandom(), $urandom(), $urandom(), mag);
  endtask

  // drain, then give the sequencer time to settle before register writes
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid = 0;
    while (sb.beats_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // random colormap, mostly ascending thresholds around zero
  task automatic load_keys(output int lo_t, output int hi_t);
    int t;
    t = -$urandom_range(0, 200000);
    lo_t = t;
    for (int i = 0; i < 5; i++) begin
      if ($urandom_range(0, 7) == 0) t = t - $urandom_range(0, 5000);
      else if ($urandom_range(0, 7) != 0) t = t + $urandom_range(0, 100000);
      apb_write(3 + i, {8'h00, t[31:0], 24'($urandom())});
    end
    hi_t = t + 1000;
    if (hi_t <= lo_t) hi_t = lo_t + 1000;
    lo_t = lo_t - 1000;
  endtask

  initial begin
    int lo_t, hi_t, cols, rows, npix;
    sb.reset_state();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: requests against reset state
    send_request(OpDirect, 8'hff, 8'h00, 8'hff, 32'h0);       // pixel while closed
    send_request(OpUnused, 8'h00, 8'hff, 8'h00, 32'hffff_ffff); // unused opcode
    send_request(OpStart, 8'h00, 8'h00, 8'h00, 32'h0);         // 1x1 frame
    send_request(OpMap, 8'h00, 8'h00, 8'h00, 32'h8000_0000);   // key zero colour, done
    send_request(OpDirect, 8'h12, 8'h34, 8'h56, 32'h0);        // closed after done
    settle();

    // invalid and extreme sizes
    apb_write(RegCols, 64'd0);
    send_request(OpStart, 8'h0, 8'h0, 8'h0, 32'h0);
    settle();
    apb_write(RegCols, 64'd4097);
    send_request(OpStart, 8'h0, 8'h0, 8'h0, 32'h0);
    settle();
    apb_write(RegCols, 64'd4096);
    apb_write(RegRows, 64'd0);
    send_request(OpStart, 8'h0, 8'h0, 8'h0, 32'h0);
    settle();
    apb_write(RegRows, 64'h3fff & (-64'sd4097));
    send_request(OpStart, 8'h0, 8'h0, 8'h0, 32'h0);
    settle();
    apb_write(RegRows, 64'h3fff & (-64'sd4096));
    send_request(OpStart, 8'h0, 8'h0, 8'h0, 32'h0);
    send_request(OpDirect, 8'hff, 8'hff, 8'hff, 32'h0);
    settle();
    apb_write(RegRows, 64'd4096);
    apb_write(RegCols, 64'd8191);
    send_request(OpStart, 8'h0, 8'h0, 8'h0, 32'h0);
    settle();
    apb_write(RegCols, 64'd4095);
    send_request(OpStart, 8'h0, 8'h0, 8'h0, 32'h0);             // start while open
    send_request(OpDirect, 8'h01, 8'h02, 8'h03, 32'h0);
    settle();

    // directed colormap: two keys, below, at and above thresholds
    apb_write(RegKeys, 64'd2);
    apb_write(3, {8'h00, 32'h0001_0000, 8'hff, 8'h00, 8'h80});
    apb_write(4, {8'h00, 32'h0003_0000, 8'h00, 8'hff, 8'h01});
    apb_write(RegCols, 64'd3);
    apb_write(RegRows, 64'h3fff & (-64'sd2));
    send_request(OpStart, 8'h0, 8'h0, 8'h0, 32'h0);
    send_request(OpMap, 8'h0, 8'h0, 8'h0, 32'h8000_0000);
    send_request(OpMap, 8'h0, 8'h0, 8'h0, 32'h0001_0000);
    send_request(OpMap, 8'h0, 8'h0, 8'h0, 32'h0001_0001);
    send_request(OpMap, 8'h0, 8'h0, 8'h0, 32'h0002_0000);
    send_request(OpMap, 8'h0, 8'h0, 8'h0, 32'h0003_0000);
    send_request(OpMap, 8'h0, 8'h0, 8'h0, 32'h7fff_ffff);
    send_request(OpMap, 8'h0, 8'h0, 8'h0, 32'h0);              // frame closed
    settle();
    apb_write(RegKeys, 64'd0);                                  // treated as one
    apb_write(RegCols, 64'd1);
    apb_write(RegRows, 64'd1);
    send_request(OpStart, 8'h0, 8'h0, 8'h0, 32'h0);
    send_request(OpMap, 8'h0, 8'h0, 8'h0, 32'h7fff_ffff);
    settle();

    // random phases: small frames, random colormaps and key counts
    for (int ph = 0; ph < 12; ph++) begin
      load_keys(lo_t, hi_t);
      apb_write(RegKeys, 64'($urandom_range(0, 7)));
      cols = $urandom_range(1, 6);
      rows = $urandom_range(1, 3);
      if ($urandom_range(0, 1)) rows = -rows;
      apb_write(RegCols, 64'(cols));
      apb_write(RegRows, 64'(rows) & 64'h3fff);
      npix = cols * (rows < 0 ? -rows : rows);
      send_request(OpStart, $urandom(), $urandom(), $urandom(), $urandom());
      for (int i = 0; i < npix + 2; i++) begin
        case ($urandom_range(0, 15))
          0: send_request(OpUnused, $urandom(), $urandom(), $urandom(), $urandom());
          1: send_request(OpStart, $urandom(), $urandom(), $urandom(), $urandom());
          default: send_pixel_rand(lo_t, hi_t);
        endcase
      end
      settle();
    end

    repeat (100) @(posedge clk_i);
    if (sb.beats_q.size() != 0) sb.flag("expected bytes left over");
    if (sb.errors == 0) begin
      $display("[colormap_bmp_pixel_stream_top] OK");
    end else begin
      $display("[colormap_bmp_pixel_stream_top] ERROR");
    end
    $finish;
  end

endmodule
